>>> design/ipta_pkg.sv
// ----------------------------------------------------------------------------
// IP traffic accounting package
// Shared types, constants and the rule matching function.
// ----------------------------------------------------------------------------
package ipta_pkg;

    localparam int RULES   = 16;
    localparam int RULE_AW = $clog2(RULES);
    localparam int ENTRIES = 256;
    localparam int SLOT_AW = $clog2(ENTRIES);
    localparam int FILL_W  = SLOT_AW + 1;
    localparam int IN_W    = 208;
    localparam int OUT_W   = 168;

    typedef enum logic [2:0] {
        ACT_LOAD_PRI = 3'd0,
        ACT_LOAD_SEC = 3'd1,
        ACT_ACCOUNT  = 3'd2,
        ACT_READ     = 3'd3,
        ACT_CLEAR    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_ACCEPT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] mask;
        logic [15:0] port;
        logic [1:0]  kind;
    } rule_t;

    typedef rule_t [RULES-1:0] rule_tab_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DIR,
        ST_SEARCH,
        ST_CMP,
        ST_UPD,
        ST_NEW,
        ST_READ,
        ST_READ_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic match;
        logic dir_next;
        logic scan_clr;
        logic scan_inc;
        logic upd;
        logic new_emit;
        logic read_emit;
    } cmd_t;

    typedef struct packed {
        logic             pass_cur;
        logic             dir;
        logic             more;
        logic             scan_lt_fill;
        logic             hit;
        logic             out_free;
        logic [FILL_W-1:0] fill;
    } sts_t;

    // The first rule in use that matches decides; no match rejects.
    function automatic logic list_pass(input rule_tab_t tab, input logic [31:0] ip,
                                       input logic [15:0] port);
        logic res;
        res = 1'b0;
        for (int r = RULES - 1; r >= 0; r--) begin
            if ((tab[r].kind == KIND_REJECT || tab[r].kind == KIND_ACCEPT) &&
                ((ip & tab[r].mask) == tab[r].addr) &&
                (tab[r].port == 16'd0 || tab[r].port == port)) begin
                res = (tab[r].kind == KIND_ACCEPT);
            end
        end
        return res;
    endfunction

endpackage

>>> design/ipta_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ipta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/ipta_ctrl.sv
// ----------------------------------------------------------------------------
// IP traffic accounting controller
// Sequences rule matching, slot search, counter update and result output.
// ----------------------------------------------------------------------------
module ipta_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic [2:0]     s_tuser,
    input  ipta_pkg::sts_t sts,
    output ipta_pkg::cmd_t cmd,
    output logic           s_tready
);

    ipta_pkg::state_t state_reg;
    ipta_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ipta_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ipta_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == ipta_pkg::ACT_ACCOUNT) begin
                        state_next = ipta_pkg::ST_MATCH;
                    end else if (s_tuser == ipta_pkg::ACT_READ) begin
                        state_next = ipta_pkg::ST_READ;
                    end
                end
            end
            ipta_pkg::ST_MATCH: state_next = ipta_pkg::ST_DIR;
            ipta_pkg::ST_DIR: begin
                if (sts.pass_cur) begin
                    state_next = ipta_pkg::ST_SEARCH;
                end else if (sts.dir) begin
                    state_next = ipta_pkg::ST_IDLE;
                end
            end
            ipta_pkg::ST_SEARCH: begin
                state_next = sts.scan_lt_fill ? ipta_pkg::ST_CMP : ipta_pkg::ST_NEW;
            end
            ipta_pkg::ST_CMP: begin
                state_next = sts.hit ? ipta_pkg::ST_UPD : ipta_pkg::ST_SEARCH;
            end
            ipta_pkg::ST_UPD, ipta_pkg::ST_NEW: begin
                if (sts.out_free) begin
                    state_next = sts.more ? ipta_pkg::ST_DIR : ipta_pkg::ST_IDLE;
                end
            end
            ipta_pkg::ST_READ: state_next = ipta_pkg::ST_READ_OUT;
            ipta_pkg::ST_READ_OUT: begin
                if (sts.out_free) begin
                    state_next = ipta_pkg::ST_IDLE;
                end
            end
            default: state_next = ipta_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ipta_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ipta_pkg::ST_MATCH: cmd.match = 1'b1;
            ipta_pkg::ST_DIR: begin
                cmd.scan_clr = sts.pass_cur;
                cmd.dir_next = !sts.pass_cur && !sts.dir;
            end
            ipta_pkg::ST_CMP: cmd.scan_inc = !sts.hit;
            ipta_pkg::ST_UPD: begin
                cmd.upd      = sts.out_free;
                cmd.dir_next = sts.out_free && sts.more;
            end
            ipta_pkg::ST_NEW: begin
                cmd.new_emit = sts.out_free;
                cmd.dir_next = sts.out_free && sts.more;
            end
            ipta_pkg::ST_READ_OUT: cmd.read_emit = sts.out_free;
            ipta_pkg::ST_SEARCH, ipta_pkg::ST_READ: cmd = '0;
            default: cmd = '0;
        endcase
    end

endmodule

>>> design/ipta_dp.sv
// ----------------------------------------------------------------------------
// IP traffic accounting datapath
// Rule tables, slot memories, fill count, search pointer and result register.
// ----------------------------------------------------------------------------
module ipta_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ipta_pkg::IN_W-1:0]  s_tdata,
    input  logic [2:0]                 s_tuser,
    input  ipta_pkg::cmd_t             cmd,
    output ipta_pkg::sts_t             sts,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ipta_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int AW = ipta_pkg::SLOT_AW;
    localparam int FW = ipta_pkg::FILL_W;

    ipta_pkg::rule_tab_t pri_reg;
    ipta_pkg::rule_tab_t sec_reg;
    logic [ipta_pkg::IN_W-1:0] item_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] scan_reg;
    logic          dir_reg;
    logic [1:0]    pass_reg;

    logic [31:0]  out_addr_reg;
    logic [63:0]  out_in_reg;
    logic [63:0]  out_out_reg;
    logic         out_valid_reg;
    logic         out_full_reg;
    logic         out_dir_reg;
    logic         out_last_reg;
    logic         m_tvalid_reg;

    logic [7:0]   in_index;
    ipta_pkg::rule_t new_rule;
    logic         rule_idx_ok;

    logic [31:0]  src_ip;
    logic [31:0]  dst_ip;
    logic [15:0]  src_port;
    logic [15:0]  dst_port;
    logic [15:0]  pkt_length;
    logic [7:0]   index;
    logic [31:0]  cur_ip;

    logic [31:0]  addr_rd;
    logic [127:0] cnt_rd;
    logic         addr_we;
    logic         cnt_we;
    logic [AW-1:0] cnt_wa;
    logic [127:0] cnt_wd;
    logic         is_full;
    logic         out_free;
    logic         emit;
    logic [63:0]  len64;
    logic         read_ok;

    assign in_index  = s_tdata[119:112];
    assign new_rule  = '{addr: s_tdata[151:120], mask: s_tdata[183:152],
                         port: s_tdata[199:184], kind: s_tdata[201:200]};
    assign rule_idx_ok = {1'b0, in_index} < 9'(ipta_pkg::RULES);

    assign src_ip     = item_reg[31:0];
    assign dst_ip     = item_reg[63:32];
    assign src_port   = item_reg[79:64];
    assign dst_port   = item_reg[95:80];
    assign pkt_length = item_reg[111:96];
    assign index      = item_reg[119:112];
    assign cur_ip     = dir_reg ? dst_ip : src_ip;
    assign len64      = {48'd0, pkt_length};

    assign is_full  = (fill_reg == FW'(ipta_pkg::ENTRIES));
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = cmd.upd || cmd.new_emit || cmd.read_emit;
    assign read_ok  = ({1'b0, index} < 9'(ipta_pkg::ENTRIES)) &&
                      (FW'(index) < fill_reg);

    always_comb begin
        addr_we = cmd.new_emit && !is_full;
        cnt_we  = cmd.upd || addr_we;
        cnt_wa  = cmd.upd ? scan_reg[AW-1:0] : fill_reg[AW-1:0];
        if (cmd.upd) begin
            cnt_wd = dir_reg ? {cnt_rd[127:64] + len64, cnt_rd[63:0]}
                             : {cnt_rd[127:64], cnt_rd[63:0] + len64};
        end else begin
            cnt_wd = dir_reg ? {len64, 64'd0} : {64'd0, len64};
        end
    end

    ipta_ram #(.WIDTH(32), .DEPTH(ipta_pkg::ENTRIES)) u_addr_ram (
        .aclk    (aclk),
        .wr_en   (addr_we),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (cur_ip),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (addr_rd)
    );

    ipta_ram #(.WIDTH(128), .DEPTH(ipta_pkg::ENTRIES)) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_wa),
        .wr_data (cnt_wd),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (cnt_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ipta_pkg::RULES; r++) begin
                pri_reg[r].kind <= ipta_pkg::KIND_UNUSED;
                sec_reg[r].kind <= ipta_pkg::KIND_UNUSED;
            end
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (s_tuser == ipta_pkg::ACT_LOAD_PRI && rule_idx_ok) begin
                    pri_reg[in_index[ipta_pkg::RULE_AW-1:0]] <= new_rule;
                end
                if (s_tuser == ipta_pkg::ACT_LOAD_SEC && rule_idx_ok) begin
                    sec_reg[in_index[ipta_pkg::RULE_AW-1:0]] <= new_rule;
                end
                if (s_tuser == ipta_pkg::ACT_CLEAR) begin
                    fill_reg <= '0;
                end
            end
            if (addr_we) begin
                fill_reg <= fill_reg + FW'(1);
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_tdata;
            scan_reg <= FW'(in_index);
        end
        if (cmd.match) begin
            pass_reg[0] <= ipta_pkg::list_pass(pri_reg, src_ip, src_port) &&
                           ipta_pkg::list_pass(sec_reg, dst_ip, dst_port);
            pass_reg[1] <= ipta_pkg::list_pass(pri_reg, dst_ip, dst_port) &&
                           ipta_pkg::list_pass(sec_reg, src_ip, src_port);
            dir_reg     <= 1'b0;
        end
        if (cmd.dir_next) begin
            dir_reg <= 1'b1;
        end
        if (cmd.scan_clr) begin
            scan_reg <= '0;
        end
        if (cmd.scan_inc) begin
            scan_reg <= scan_reg + FW'(1);
        end
        if (cmd.upd || cmd.new_emit) begin
            out_addr_reg <= cur_ip;
            out_dir_reg  <= dir_reg;
            out_last_reg <= dir_reg || !pass_reg[1];
            out_full_reg <= cmd.new_emit && is_full;
            out_valid_reg <= !(cmd.new_emit && is_full);
            if (cmd.new_emit && is_full) begin
                out_in_reg  <= '0;
                out_out_reg <= '0;
            end else begin
                out_in_reg  <= cnt_wd[127:64];
                out_out_reg <= cnt_wd[63:0];
            end
        end
        if (cmd.read_emit) begin
            out_addr_reg  <= read_ok ? addr_rd : 32'd0;
            out_in_reg    <= read_ok ? cnt_rd[127:64] : 64'd0;
            out_out_reg   <= read_ok ? cnt_rd[63:0] : 64'd0;
            out_valid_reg <= read_ok;
            out_full_reg  <= 1'b0;
            out_dir_reg   <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    always_comb begin
        sts.pass_cur     = pass_reg[dir_reg];
        sts.dir          = dir_reg;
        sts.more         = !dir_reg && pass_reg[1];
        sts.scan_lt_fill = scan_reg < fill_reg;
        sts.hit          = (addr_rd == cur_ip);
        sts.out_free     = out_free;
        sts.fill         = fill_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_full_reg, out_valid_reg, out_out_reg, out_in_reg,
                       out_addr_reg};
    assign m_tuser  = out_dir_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> design/ip_traffic_accounting_core.sv
// ----------------------------------------------------------------------------
// IP traffic accounting core
// Per-address byte accounting with primary and secondary first-match rules.
// ----------------------------------------------------------------------------
// One request is handled at a time. Rule loads, clears and unknown actions
// complete on acceptance. A slot read passes through a read state and an
// output state. An account request first matches the rules, then for each
// direction that passes the address search walks the occupied slots of the
// slot memory one entry per read, then updates the entry found, adds a new
// one or reports a full table. No clearing pass is needed after reset.
module ip_traffic_accounting_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // src_ip, dst_ip, src_port, dst_port, pkt_length, index, rule_addr,
    // rule_mask, rule_port, rule_kind, zero fill
    input  logic [ipta_pkg::IN_W-1:0]  s_tdata,
    // action
    input  logic [2:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // entry_addr, bytes_in, bytes_out, entry_valid, table_full, zero fill
    output logic [ipta_pkg::OUT_W-1:0] m_tdata,
    // direction
    output logic                       m_tuser,
    output logic                       m_tlast
);

    ipta_pkg::cmd_t cmd;
    ipta_pkg::sts_t sts;

    ipta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    ipta_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.fill <= ipta_pkg::FILL_W'(ipta_pkg::ENTRIES))
        else $error("Fill count beyond table size.");

    a_full_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[161]) |-> !m_tdata[160])
        else $error("Full result marked as a valid entry.");

    a_dest_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("Destination credit not marked last.");

endmodule
